/* src/positional_list_engine_unit_assert.svh */
// Assertion helpers shared by the list engine files.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define PLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define PLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* src/ple_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

    localparam int TYPE_W      = 3;
    localparam int POS_W       = 7;
    localparam int HANDLE_IO_W = 11;
    localparam int LEN_IO_W    = 7;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    typedef enum logic [TYPE_W-1:0] {
        REQ_INS_HEAD = 3'd0,
        REQ_INS_TAIL = 3'd1,
        REQ_INS_POS  = 3'd2,
        REQ_REM_HEAD = 3'd3,
        REQ_REM_TAIL = 3'd4,
        REQ_REM_POS  = 3'd5
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Finished request handed from the sequencer to the output register.
    typedef struct packed {
        logic                   valid;
        t_status                status;
        logic [HANDLE_IO_W-1:0] removed;
        logic [LEN_IO_W-1:0]    list_len;
    } t_rsp;

endpackage

`default_nettype wire

/* src/ple_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module ple_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  wire logic [WIDTH-1:0]                 i_wr_data,
    input  wire logic                             i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]         i_rd_addr,
    output logic      [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* src/ple_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_engine_unit_assert.svh"

module ple_ctrl #(
    parameter int LIST_DEPTH = 64,
    parameter int SW         = 11
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_req_valid,
    input  wire ple_pkg::t_req_type              i_req_type,
    input  wire logic [ple_pkg::POS_W-1:0]       i_position,
    input  wire logic [SW-1:0]                   i_handle,
    output logic                                 o_idle,
    input  wire logic                            i_rsp_take,
    output ple_pkg::t_rsp                        o_rsp,
    output logic                                 o_wr_en,
    output logic [$clog2(LIST_DEPTH)-1:0]        o_wr_addr,
    output logic [SW-1:0]                        o_wr_data,
    output logic                                 o_rd_en,
    output logic [$clog2(LIST_DEPTH)-1:0]        o_rd_addr,
    input  wire logic [SW-1:0]                   i_rd_data
);

    import ple_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int LW = $clog2(LIST_DEPTH + 1);
    localparam int CW = (LW > POS_W) ? LW : POS_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,
        S_TAKE = 5'b00100,
        S_REM  = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    t_state          r_state,  n_state;
    logic [LW-1:0]   r_len,    n_len;
    logic [AW-1:0]   r_idx,    n_idx;
    logic [AW-1:0]   r_pos,    n_pos;
    logic [AW-1:0]   r_wa,     n_wa;
    logic            r_pend,   n_pend;
    logic [SW-1:0]   r_handle, n_handle;
    logic [SW-1:0]   r_taken,  n_taken;
    t_status         r_status, n_status;

    logic [CW-1:0]   len_c;
    logic [CW-1:0]   pos_c;
    logic [CW-1:0]   eff_pos;
    logic            is_ins;
    logic            is_rem;
    logic            more_rem;

    assign len_c = CW'(r_len);
    assign pos_c = CW'(i_position);
    assign more_rem = (LW'(r_idx) + LW'(1)) < r_len;

    // Resolve the request kind to one effective list position.
    always_comb begin
        eff_pos = '0;
        is_ins  = 1'b0;
        is_rem  = 1'b0;
        unique case (i_req_type)
            REQ_INS_HEAD: begin
                is_ins = 1'b1;
            end
            REQ_INS_TAIL: begin
                is_ins  = 1'b1;
                eff_pos = len_c;
            end
            REQ_INS_POS: begin
                is_ins  = 1'b1;
                eff_pos = pos_c;
            end
            REQ_REM_HEAD: begin
                is_rem = 1'b1;
            end
            REQ_REM_TAIL: begin
                is_rem  = 1'b1;
                eff_pos = len_c - CW'(1);
            end
            REQ_REM_POS: begin
                is_rem  = 1'b1;
                eff_pos = pos_c;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_wa     = r_wa;
        n_pend   = r_pend;
        n_handle = r_handle;
        n_taken  = r_taken;
        n_status = r_status;
        o_wr_en   = 1'b0;
        o_wr_addr = r_wa;
        o_wr_data = i_rd_data;
        o_rd_en   = 1'b0;
        o_rd_addr = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_status = ST_DONE;
                    n_taken  = '0;
                    n_pend   = 1'b0;
                    n_state  = S_RESP;
                    if (is_ins) begin
                        if (r_len == LW'(LIST_DEPTH)) begin
                            n_status = ST_FULL;
                        end else if (eff_pos > len_c) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_idx    = r_len[AW-1:0];
                            n_pos    = eff_pos[AW-1:0];
                            n_handle = i_handle;
                            n_state  = S_INS;
                        end
                    end else if (is_rem) begin
                        if (r_len == '0) begin
                            n_status = ST_EMPTY;
                        end else if (eff_pos >= len_c) begin
                            n_status = ST_RANGE;
                        end else begin
                            // Fetch the entry that leaves the list.
                            o_rd_en   = 1'b1;
                            o_rd_addr = eff_pos[AW-1:0];
                            n_idx     = eff_pos[AW-1:0];
                            n_state   = S_TAKE;
                        end
                    end
                end
            end
            S_INS: begin
                // Walk from the tail down, moving each entry up by one slot.
                if (r_pend) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_wa;
                    o_wr_data = i_rd_data;
                end else if (r_idx == r_pos) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_pos;
                    o_wr_data = r_handle;
                    n_len     = r_len + LW'(1);
                    n_state   = S_RESP;
                end
                if (r_idx != r_pos) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_idx - AW'(1);
                    n_pend    = 1'b1;
                    n_wa      = r_idx;
                    n_idx     = r_idx - AW'(1);
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_TAKE: begin
                n_taken = i_rd_data;
                n_state = S_REM;
            end
            S_REM: begin
                // Walk toward the tail, moving each entry down by one slot.
                if (r_pend) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_wa;
                    o_wr_data = i_rd_data;
                end
                if (more_rem) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_idx + AW'(1);
                    n_pend    = 1'b1;
                    n_wa      = r_idx;
                    n_idx     = r_idx + AW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_len   = r_len - LW'(1);
                        n_state = S_RESP;
                    end
                end
            end
            S_RESP: begin
                if (i_rsp_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_wa     <= n_wa;
        r_handle <= n_handle;
        r_taken  <= n_taken;
        r_status <= n_status;
    end

    assign o_idle = (r_state == S_IDLE);

    always_comb begin
        o_rsp          = '0;
        o_rsp.valid    = (r_state == S_RESP);
        o_rsp.status   = r_status;
        o_rsp.removed  = HANDLE_IO_W'(r_taken);
        o_rsp.list_len = LEN_IO_W'(r_len);
    end

    `PLE_ASSERT_IMP(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= LW'(LIST_DEPTH), "length above capacity")
    `PLE_ASSERT_IMP(a_full_len, i_clk, i_rst_n, (r_state == S_RESP) && (r_status == ST_FULL), r_len == LW'(LIST_DEPTH), "full status on a list with room")
    `PLE_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_req_valid && (r_state == S_IDLE), r_state != S_IDLE, "accepted request did not start")

endmodule

`default_nettype wire

/* src/positional_list_engine_unit.sv */
// Positional list engine: an ordered list of entry handles with room for
// LIST_DEPTH entries, kept in list order in one RAM (slot 0 is the head).
// Requests arrive on the slave stream: tuser carries the request kind and
// tdata carries the position and the handle. Each request gives exactly one
// transaction on the master stream with the status in tuser, and the removed
// handle and the new list length in tdata.
// A rejected or unknown request goes straight to its result. An insert or a
// removal first moves the entries from the position toward the tail by one
// slot; one slot moves per cycle through the single RAM write port. The
// slave side is ready only while no request is in progress.
// A finished result waits in the output register, and the next request is
// accepted while it waits; if a second result finishes before the first is
// taken, the sequencer holds it and stays busy until the receiver drains.
// Reset (synchronous, active low) empties the list and drops any result;
// RAM contents are not cleared, since only slots below the length are read.
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_engine_unit_assert.svh"

module positional_list_engine_unit #(
    parameter int LIST_DEPTH   = 64,
    parameter int HANDLE_WIDTH = 11
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // [6:0] position, [17:7] entry_handle, [23:18] zero
    input  wire logic [ple_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // [2:0] req_type
    input  wire logic [ple_pkg::TYPE_W-1:0]         i_s_tuser,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // [10:0] removed_handle, [17:11] list_length, [23:18] zero
    output logic      [ple_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // [1:0] status
    output logic      [ple_pkg::STATUS_W-1:0]       o_m_tuser
);

    import ple_pkg::*;

    // Stored handle width: the handle field itself is only HANDLE_IO_W bits.
    localparam int SW = (HANDLE_WIDTH < HANDLE_IO_W) ? HANDLE_WIDTH : HANDLE_IO_W;
    localparam int AW = $clog2(LIST_DEPTH);

    t_rsp                    rsp;
    logic                    idle;
    logic                    rsp_take;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [SW-1:0]           wr_data;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [SW-1:0]           rd_data;

    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [HANDLE_IO_W-1:0]  r_out_removed;
    logic [LEN_IO_W-1:0]     r_out_len;

    assign o_s_tready = idle;

    // The output register takes a result when empty or being drained.
    assign rsp_take = rsp.valid && (!r_out_valid || i_m_tready);

    ple_ctrl #(
        .LIST_DEPTH (LIST_DEPTH),
        .SW         (SW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .i_req_type  (t_req_type'(i_s_tuser)),
        .i_position  (i_s_tdata[POS_W-1:0]),
        .i_handle    (i_s_tdata[POS_W +: SW]),
        .o_idle      (idle),
        .i_rsp_take  (rsp_take),
        .o_rsp       (rsp),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    ple_ram #(
        .WIDTH (SW),
        .DEPTH (LIST_DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_take) begin
            r_out_status  <= rsp.status;
            r_out_removed <= rsp.removed;
            r_out_len     <= rsp.list_len;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {(M_TDATA_W - HANDLE_IO_W - LEN_IO_W)'(0), r_out_len, r_out_removed};

    `PLE_ASSERT_NXT(a_rsp_held, i_clk, i_rst_n, rsp.valid && r_out_valid && !i_m_tready, rsp.valid, "finished result dropped while output stalled")
    `PLE_ASSERT_IMP(a_empty_len, i_clk, i_rst_n, r_out_valid && (r_out_status == ST_EMPTY), r_out_len == '0, "empty status with nonzero length")

endmodule

`default_nettype wire
